// ===== design/tlgb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlgb_pkg
// Commands, status codes, register indexes and field widths of the tiled
// light grid binner.
// ----------------------------------------------------------------------------
package tlgb_pkg;

	localparam int CMD_W    = 3;
	localparam int COORD_W  = 12;
	localparam int LIGHT_W  = 10;
	localparam int TSEL_W   = 10;
	localparam int LPOS_W   = 15;
	localparam int STATUS_W = 2;
	localparam int OFFSET_W = 16;
	localparam int TCOUNT_W = 6;
	localparam int TOTAL_W  = 16;
	localparam int SCREEN_W = 13;
	localparam int TSIZE_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int QUOT_W   = 14;

	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FINALISE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RD_TILE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RD_ENTRY = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_X   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_Y   = 2'd3;

endpackage

// ===== design/tlgb_item_if.sv =====
// ----------------------------------------------------------------------------
// tlgb_item_if
// Command channel of the tiled light grid binner.
// ----------------------------------------------------------------------------
interface tlgb_item_if
	import tlgb_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [COORD_W-1:0]   first_tile_x;
	logic [COORD_W-1:0]   first_tile_y;
	logic [COORD_W-1:0]   last_tile_x;
	logic [COORD_W-1:0]   last_tile_y;
	logic [LIGHT_W-1:0]   light_id;
	logic [TSEL_W-1:0]    tile_select;
	logic [LPOS_W-1:0]    list_position;

	modport source (output valid, command, first_tile_x, first_tile_y, last_tile_x,
		last_tile_y, light_id, tile_select, list_position, input ready);
	modport sink (input valid, command, first_tile_x, first_tile_y, last_tile_x,
		last_tile_y, light_id, tile_select, list_position, output ready);
endinterface

// ===== design/tlgb_result_if.sv =====
// ----------------------------------------------------------------------------
// tlgb_result_if
// Result channel of the tiled light grid binner.
// ----------------------------------------------------------------------------
interface tlgb_result_if
	import tlgb_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [OFFSET_W-1:0]  tile_offset;
	logic [TCOUNT_W-1:0]  tile_light_count;
	logic [LIGHT_W-1:0]   light_out;
	logic [TOTAL_W-1:0]   total_entries;

	modport source (output valid, status, tile_offset, tile_light_count, light_out,
		total_entries, input ready);
	modport sink (input valid, status, tile_offset, tile_light_count, light_out,
		total_entries, output ready);
endinterface

// ===== design/tiled_light_grid_binner.sv =====
// ----------------------------------------------------------------------------
// tiled_light_grid_binner
// Bins light indices into screen tiles and packs the tile lists into one
// flat list with a start offset and a count for every tile.
// ----------------------------------------------------------------------------
// Channel   Direction  Fields
// items     in         command, tile rectangle, light_id, tile_select, list_position
// results   out        status, tile_offset, tile_light_count, light_out, total_entries
// cfg       in         cfg_wr_en, cfg_index, cfg_data
//
// Clear runs a 14-step divider per axis and a sweep that zeroes the tile count
// memory one entry per cycle.
// Insert does a count memory read-modify-write for every covered tile.
// Finalise copies every tile's stored entries into the flat list; reads go through a wait state.
// After reset the same count sweep runs with items held off.
// One command is worked at a time; a waiting result does not stop the next transfer.
// ----------------------------------------------------------------------------
module tiled_light_grid_binner
	import tlgb_pkg::*;
#(
	parameter int MAX_TILES    = 1024,
	parameter int MAX_PER_TILE = 32,
	parameter int MAX_LIGHTS   = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tlgb_item_if.sink             items,
	tlgb_result_if.source         results
);

	localparam int TIW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int TCW = $clog2(MAX_TILES + 1);
	localparam int CW  = $clog2(MAX_PER_TILE + 1);
	localparam int LD  = MAX_TILES * MAX_PER_TILE;
	localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
	localparam int LLW = $clog2(LD + 1);
	localparam int TQW = 2 * COORD_W + 1;
	localparam int REMW = TSIZE_W + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_MUL, S_CHK, S_SWEEP, S_INS_SETUP, S_INS_RD, S_INS_WR,
		S_FIN_RDC, S_FIN_CNT, S_FIN_RDL, S_FIN_WRL, S_RD_WAIT, S_DONE
	} state_t;

	typedef struct packed {
		logic [LLW-1:0] start;
		logic [CW-1:0]  count;
	} tile_entry_t;

	state_t state_q;

	logic [SCREEN_W-1:0] screen_width_q, screen_height_q;
	logic [TSIZE_W-1:0]  tile_size_x_q, tile_size_y_q;

	logic [COORD_W-1:0] ta_q, td_q;
	logic [TCW-1:0]     tile_count_q;
	logic [LLW-1:0]     entry_total_q, packed_q, off_q;
	logic               fin_q, report_q, ovf_q;

	logic [QUOT_W-1:0]  qx_q, qy_q;
	logic [REMW-1:0]    rx_q, ry_q;
	logic [3:0]         step_q;
	logic [2*COORD_W-1:0] prod_q;

	logic [CMD_W-1:0]   cmd_q;
	logic [COORD_W-1:0] fx_q, fy_q, lx_q, ly_q, x_q, y_q;
	logic [LIGHT_W-1:0] id_q;
	logic [TSEL_W-1:0]  tsel_q;
	logic [LPOS_W-1:0]  lpos_q;
	logic [TQW-1:0]     base_q, t_q;
	logic [CW-1:0]      k_q, c_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [OFFSET_W-1:0] res_offset_q;
	logic [TCOUNT_W-1:0] res_count_q;
	logic [LIGHT_W-1:0]  res_light_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [OFFSET_W-1:0] out_offset_q;
	logic [TCOUNT_W-1:0] out_count_q;
	logic [LIGHT_W-1:0]  out_light_q;
	logic [TOTAL_W-1:0]  out_total_q;

	logic [CW-1:0]      cnt_mem [MAX_TILES];
	logic [LIGHT_W-1:0] list_mem [LD];
	tile_entry_t        tile_mem [MAX_TILES];
	logic [LIGHT_W-1:0] flat_mem [LD];

	logic [CW-1:0]      cnt_rd_q;
	logic [LIGHT_W-1:0] list_rd_q, flat_rd_q;
	tile_entry_t        tile_rd_q;

	logic               accept;
	logic               cnt_we, cnt_re;
	logic [TIW-1:0]     cnt_wa, cnt_ra;
	logic [CW-1:0]      cnt_wd;
	logic               list_we;
	logic [LAW-1:0]     list_wa, list_ra;
	logic [TQW-1:0]     ins_t;
	logic               ins_store;
	logic [REMW-1:0]    rx_sh, ry_sh;

	assign accept       = items.valid && items.ready;
	assign items.ready  = (state_q == S_IDLE);
	assign ins_t        = base_q + TQW'(x_q);
	assign ins_store    = (t_q < TQW'(MAX_TILES)) && (cnt_rd_q < CW'(MAX_PER_TILE));
	assign rx_sh        = {rx_q[REMW-2:0], qx_q[QUOT_W-1]};
	assign ry_sh        = {ry_q[REMW-2:0], qy_q[QUOT_W-1]};

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = t_q[TIW-1:0];
		cnt_wd = '0;
		cnt_re = 1'b0;
		cnt_ra = t_q[TIW-1:0];
		if (state_q == S_SWEEP) begin
			cnt_we = 1'b1;
		end else if (state_q == S_INS_WR) begin
			cnt_we = ins_store;
			cnt_wd = cnt_rd_q + CW'(1);
		end
		if (state_q == S_INS_RD) begin
			cnt_re = 1'b1;
			cnt_ra = ins_t[TIW-1:0];
		end else if (state_q == S_FIN_RDC) begin
			cnt_re = 1'b1;
		end
		list_we = (state_q == S_INS_WR) && ins_store;
		list_wa = LAW'(LAW'(t_q[TIW-1:0]) * LAW'(MAX_PER_TILE) + LAW'(cnt_rd_q));
		list_ra = LAW'(LAW'(t_q[TIW-1:0]) * LAW'(MAX_PER_TILE) + LAW'(k_q));
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_ra];
		end
		if (list_we) begin
			list_mem[list_wa] <= id_q;
		end
		if (state_q == S_FIN_RDL) begin
			list_rd_q <= list_mem[list_ra];
		end
		if (state_q == S_FIN_CNT) begin
			tile_mem[t_q[TIW-1:0]] <= '{start: off_q, count: cnt_rd_q};
		end
		if (accept) begin
			tile_rd_q <= tile_mem[TIW'(items.tile_select)];
		end
		if (state_q == S_FIN_WRL) begin
			flat_mem[LAW'(off_q)] <= list_rd_q;
		end
		if (accept) begin
			flat_rd_q <= flat_mem[LAW'(items.list_position)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_W'(1920);
			screen_height_q <= SCREEN_W'(1080);
			tile_size_x_q   <= TSIZE_W'(32);
			tile_size_y_q   <= TSIZE_W'(32);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				REG_TILE_SIZE_X:   tile_size_x_q   <= cfg_data[TSIZE_W-1:0];
				REG_TILE_SIZE_Y:   tile_size_y_q   <= cfg_data[TSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			report_q      <= 1'b0;
			ta_q          <= '0;
			td_q          <= '0;
			tile_count_q  <= '0;
			entry_total_q <= '0;
			packed_q      <= '0;
			fin_q         <= 1'b0;
			t_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (results.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= items.command;
						fx_q         <= items.first_tile_x;
						fy_q         <= items.first_tile_y;
						lx_q         <= items.last_tile_x;
						ly_q         <= items.last_tile_y;
						id_q         <= items.light_id;
						tsel_q       <= items.tile_select;
						lpos_q       <= items.list_position;
						res_status_q <= ST_OK;
						res_offset_q <= '0;
						res_count_q  <= '0;
						res_light_q  <= '0;
						unique case (items.command)
							CMD_CLEAR: begin
								entry_total_q <= '0;
								packed_q      <= '0;
								fin_q         <= 1'b0;
								qx_q   <= QUOT_W'(screen_width_q) + QUOT_W'(tile_size_x_q)
									- QUOT_W'(1);
								qy_q   <= QUOT_W'(screen_height_q) + QUOT_W'(tile_size_y_q)
									- QUOT_W'(1);
								rx_q   <= '0;
								ry_q   <= '0;
								step_q <= '0;
								state_q <= S_DIV;
							end
							CMD_INSERT: begin
								if (items.first_tile_x > items.last_tile_x ||
									items.first_tile_y > items.last_tile_y ||
									items.last_tile_x >= ta_q || items.last_tile_y >= td_q ||
									32'(items.light_id) >= MAX_LIGHTS) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else begin
									ovf_q   <= 1'b0;
									state_q <= S_INS_SETUP;
								end
							end
							CMD_FINALISE: begin
								t_q   <= '0;
								off_q <= '0;
								if (tile_count_q == '0) begin
									packed_q <= '0;
									fin_q    <= 1'b1;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_FIN_RDC;
								end
							end
							CMD_RD_TILE, CMD_RD_ENTRY: state_q <= S_RD_WAIT;
							default: begin
								res_status_q <= ST_RANGE;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_DIV: begin
					if (rx_sh >= REMW'(tile_size_x_q)) begin
						rx_q <= rx_sh - REMW'(tile_size_x_q);
						qx_q <= {qx_q[QUOT_W-2:0], 1'b1};
					end else begin
						rx_q <= rx_sh;
						qx_q <= {qx_q[QUOT_W-2:0], 1'b0};
					end
					if (ry_sh >= REMW'(tile_size_y_q)) begin
						ry_q <= ry_sh - REMW'(tile_size_y_q);
						qy_q <= {qy_q[QUOT_W-2:0], 1'b1};
					end else begin
						ry_q <= ry_sh;
						qy_q <= {qy_q[QUOT_W-2:0], 1'b0};
					end
					step_q <= step_q + 4'd1;
					if (step_q == 4'(QUOT_W - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= qx_q[COORD_W-1:0] * qy_q[COORD_W-1:0];
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (tile_size_x_q == '0 || tile_size_y_q == '0 ||
						qx_q[QUOT_W-1:COORD_W] != '0 || qy_q[QUOT_W-1:COORD_W] != '0 ||
						32'(prod_q) > MAX_TILES) begin
						ta_q         <= '0;
						td_q         <= '0;
						tile_count_q <= '0;
						res_status_q <= ST_TOO_LARGE;
					end else begin
						ta_q         <= qx_q[COORD_W-1:0];
						td_q         <= qy_q[COORD_W-1:0];
						tile_count_q <= TCW'(prod_q);
					end
					t_q      <= '0;
					report_q <= 1'b1;
					state_q  <= S_SWEEP;
				end
				S_SWEEP: begin
					t_q <= t_q + TQW'(1);
					if (t_q == TQW'(MAX_TILES - 1)) begin
						state_q <= report_q ? S_DONE : S_IDLE;
					end
				end
				S_INS_SETUP: begin
					base_q  <= TQW'(fy_q) * TQW'(ta_q);
					x_q     <= fx_q;
					y_q     <= fy_q;
					state_q <= S_INS_RD;
				end
				S_INS_RD: begin
					t_q     <= ins_t;
					state_q <= S_INS_WR;
				end
				S_INS_WR: begin
					if (t_q < TQW'(MAX_TILES)) begin
						if (ins_store) begin
							entry_total_q <= entry_total_q + LLW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (x_q == lx_q) begin
						if (y_q == ly_q) begin
							res_status_q <= (ovf_q || (t_q < TQW'(MAX_TILES) && !ins_store))
								? ST_OVERFLOW : ST_OK;
							state_q <= S_DONE;
						end else begin
							y_q     <= y_q + COORD_W'(1);
							x_q     <= fx_q;
							base_q  <= base_q + TQW'(ta_q);
							state_q <= S_INS_RD;
						end
					end else begin
						x_q     <= x_q + COORD_W'(1);
						state_q <= S_INS_RD;
					end
				end
				S_FIN_RDC: state_q <= S_FIN_CNT;
				S_FIN_CNT: begin
					c_q     <= cnt_rd_q;
					k_q     <= '0;
					state_q <= S_FIN_RDL;
				end
				S_FIN_RDL: begin
					if (k_q < c_q) begin
						state_q <= S_FIN_WRL;
					end else if (t_q + TQW'(1) == TQW'(tile_count_q)) begin
						packed_q <= off_q;
						fin_q    <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						t_q     <= t_q + TQW'(1);
						state_q <= S_FIN_RDC;
					end
				end
				S_FIN_WRL: begin
					off_q   <= off_q + LLW'(1);
					k_q     <= k_q + CW'(1);
					state_q <= S_FIN_RDL;
				end
				S_RD_WAIT: begin
					if (cmd_q == CMD_RD_TILE) begin
						if (32'(tsel_q) < 32'(tile_count_q)) begin
							if (fin_q) begin
								res_offset_q <= OFFSET_W'(tile_rd_q.start);
								res_count_q  <= TCOUNT_W'(tile_rd_q.count);
							end
						end else begin
							res_status_q <= ST_RANGE;
						end
					end else if (32'(lpos_q) < 32'(packed_q)) begin
						res_light_q <= flat_rd_q;
					end else begin
						res_status_q <= ST_RANGE;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_offset_q <= res_offset_q;
						out_count_q  <= res_count_q;
						out_light_q  <= res_light_q;
						out_total_q  <= TOTAL_W'(entry_total_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid            = out_valid_q;
	assign results.status           = out_status_q;
	assign results.tile_offset      = out_offset_q;
	assign results.tile_light_count = out_count_q;
	assign results.light_out        = out_light_q;
	assign results.total_entries    = out_total_q;

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && items.command == CMD_CLEAR) |=> entry_total_q >= $past(entry_total_q))
		else $error("entry total decreased without a clear");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> cnt_wd <= CW'(MAX_PER_TILE))
		else $error("tile count written beyond its capacity");

	a_grid_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tile_count_q) <= MAX_TILES)
		else $error("tile grid exceeds its capacity");

	a_pack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN_WRL |-> off_q < entry_total_q)
		else $error("flat list write beyond the stored entries");

endmodule
